// ===== src/ccdpu_pkg.sv =====
// Shared constants, types and register codes for the CCD readout pixel unpacker.
package ccdpu_pkg;

    // Sensor geometry
    localparam int HALF_WIDTH    = 1500;
    localparam int MAX_ROW_PAIRS = 1000;

    // Line lengths in words (header plus data)
    localparam int LEN_UNB       = 4 * HALF_WIDTH + 4;
    localparam int LEN_BIN_FIRST = HALF_WIDTH + 6;
    localparam int LEN_BIN       = HALF_WIDTH + 4;
    localparam int NDATA_UNB     = 4 * HALF_WIDTH;
    localparam int NDATA_BIN     = HALF_WIDTH - 1;
    localparam int HDR_UNB       = 4;
    localparam int HDR_BIN_FIRST = 7;
    localparam int HDR_BIN       = 5;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int PIX_W    = 16;
    localparam int COL_W    = 12;
    localparam int ROW_W    = 11;
    localparam int PAIR_W   = COL_W - 1;
    localparam int RPAIR_W  = ROW_W - 1;
    localparam int CFG_RP_W = 10;
    localparam int WIL_W    = $clog2(LEN_UNB + 1);
    localparam int STEP_W   = 3;

    // Job queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;
    localparam logic [1:0] REG_BIN_MODE       = 2'd0;
    localparam logic [1:0] REG_START_ROW_PAIR = 2'd1;
    localparam logic [1:0] REG_ROW_PAIRS      = 2'd2;

    typedef struct packed {
        logic                bin_mode;
        logic [CFG_RP_W-1:0] start_row_pair;
        logic [CFG_RP_W-1:0] row_pairs;
    } t_cfg;

    typedef enum logic [1:0] {
        KIND_ONE,
        KIND_CELL,
        KIND_CELL2
    } t_kind;

    // One data word, ready for expansion into writes
    typedef struct packed {
        logic [PIX_W-1:0]   pix;
        logic [PAIR_W-1:0]  pair;
        logic [RPAIR_W-1:0] row_pair;
        t_kind              kind;
        logic [1:0]         quad;
        logic               final_word;
    } t_job;

endpackage

// ===== src/ccdpu_front.sv =====
// Front end: byte pairing, line and frame position tracking, word classification.
module ccdpu_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ccdpu_pkg::t_cfg           i_cfg,
    input  logic                      i_push,
    input  logic                      i_q_full,
    input  logic [ccdpu_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                      i_frame_start,
    output logic                      o_job_valid,
    output ccdpu_pkg::t_job           o_job
);

    logic [ccdpu_pkg::BYTE_W-1:0]   r_held, n_held;
    logic                           r_phase, n_phase;
    logic [ccdpu_pkg::WIL_W-1:0]    r_wil, n_wil;
    logic [ccdpu_pkg::CFG_RP_W-1:0] r_line, n_line;
    logic                           r_active, n_active;

    logic                           accept;
    logic [ccdpu_pkg::BYTE_W-1:0]   e_held;
    logic                           e_phase;
    logic [ccdpu_pkg::WIL_W-1:0]    e_wil;
    logic [ccdpu_pkg::CFG_RP_W-1:0] e_line;
    logic                           e_active;
    logic [ccdpu_pkg::WIL_W-1:0]    hdr, ndata, len, d, wil_inc;
    logic [ccdpu_pkg::WIL_W+ccdpu_pkg::PAIR_W-1:0] d_ext;
    logic [ccdpu_pkg::CFG_RP_W:0]   pair_row, line_inc;
    logic                           in_data, row_ok, line_end, last_line;

    assign accept = i_push && !i_q_full;

    // frame start clears the position before this byte is used
    always_comb begin
        e_held   = i_frame_start ? '0 : r_held;
        e_phase  = i_frame_start ? 1'b0 : r_phase;
        e_wil    = i_frame_start ? '0 : r_wil;
        e_line   = i_frame_start ? '0 : r_line;
        e_active = i_frame_start ? (i_cfg.row_pairs != '0) : r_active;
    end

    always_comb begin
        if (i_cfg.bin_mode) begin
            ndata = ccdpu_pkg::WIL_W'(ccdpu_pkg::NDATA_BIN);
            if (e_line == '0) begin
                hdr = ccdpu_pkg::WIL_W'(ccdpu_pkg::HDR_BIN_FIRST);
                len = ccdpu_pkg::WIL_W'(ccdpu_pkg::LEN_BIN_FIRST);
            end else begin
                hdr = ccdpu_pkg::WIL_W'(ccdpu_pkg::HDR_BIN);
                len = ccdpu_pkg::WIL_W'(ccdpu_pkg::LEN_BIN);
            end
        end else begin
            ndata = ccdpu_pkg::WIL_W'(ccdpu_pkg::NDATA_UNB);
            hdr   = ccdpu_pkg::WIL_W'(ccdpu_pkg::HDR_UNB);
            len   = ccdpu_pkg::WIL_W'(ccdpu_pkg::LEN_UNB);
        end
    end

    always_comb begin
        d         = e_wil - hdr;
        d_ext     = {{ccdpu_pkg::PAIR_W{1'b0}}, d};
        in_data   = (e_wil >= hdr) && (d < ndata);
        pair_row  = {1'b0, i_cfg.start_row_pair} + {1'b0, e_line};
        row_ok    = (int'(pair_row) < ccdpu_pkg::MAX_ROW_PAIRS);
        wil_inc   = e_wil + 1'b1;
        line_end  = (wil_inc >= len);
        line_inc  = {1'b0, e_line} + 1'b1;
        last_line = (line_inc >= {1'b0, i_cfg.row_pairs});
    end

    // job for a completed data word
    always_comb begin
        o_job.pix        = {i_data_byte, e_held};
        o_job.row_pair   = pair_row[ccdpu_pkg::RPAIR_W-1:0];
        o_job.quad       = d[1:0];
        o_job.final_word = line_end && last_line;
        if (i_cfg.bin_mode) begin
            o_job.pair = d_ext[ccdpu_pkg::PAIR_W-1:0];
            o_job.kind = (d == ndata - 1'b1) ? ccdpu_pkg::KIND_CELL2
                                             : ccdpu_pkg::KIND_CELL;
        end else begin
            o_job.pair = d_ext[ccdpu_pkg::PAIR_W+1:2];
            o_job.kind = ccdpu_pkg::KIND_ONE;
        end
        o_job_valid = accept && e_active && e_phase && in_data && row_ok;
    end

    always_comb begin
        n_held   = e_held;
        n_phase  = e_phase;
        n_wil    = e_wil;
        n_line   = e_line;
        n_active = e_active;
        if (e_active) begin
            if (!e_phase) begin
                n_held  = i_data_byte;
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                if (line_end) begin
                    n_wil = '0;
                    if (last_line) begin
                        n_active = 1'b0;
                    end else begin
                        n_line = line_inc[ccdpu_pkg::CFG_RP_W-1:0];
                    end
                end else begin
                    n_wil = wil_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_phase  <= 1'b0;
            r_wil    <= '0;
            r_line   <= '0;
            r_active <= 1'b0;
        end else if (accept) begin
            r_held   <= n_held;
            r_phase  <= n_phase;
            r_wil    <= n_wil;
            r_line   <= n_line;
            r_active <= n_active;
        end
    end

endmodule

// ===== src/ccdpu_queue.sv =====
// Short job queue between the front end and the write expander.
module ccdpu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  ccdpu_pkg::t_job i_wr_job,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_empty,
    output ccdpu_pkg::t_job o_rd_job
);

    ccdpu_pkg::t_job                 r_mem [ccdpu_pkg::QDEPTH];
    logic [ccdpu_pkg::QPTR_W-1:0]    r_wp, r_rp;
    logic [ccdpu_pkg::QCNT_W-1:0]    r_cnt, n_cnt;
    logic                            do_wr, do_rd;

    assign o_full   = (r_cnt == ccdpu_pkg::QCNT_W'(ccdpu_pkg::QDEPTH));
    assign o_empty  = (r_cnt == '0);
    assign o_rd_job = r_mem[r_rp];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wr_job;
        end
    end

endmodule

// ===== src/ccdpu_back.sv =====
// Back end: turns jobs into pixel writes in an output register, one a cycle if free.
module ccdpu_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  ccdpu_pkg::t_job               i_job,
    output logic                          o_q_rd,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [ccdpu_pkg::COL_W-1:0]   o_column,
    output logic [ccdpu_pkg::ROW_W-1:0]   o_row,
    output logic [ccdpu_pkg::PIX_W-1:0]   o_pixel,
    output logic                          o_run_last,
    output logic                          o_frame_done
);

    logic                          r_valid;
    logic [ccdpu_pkg::STEP_W-1:0]  r_step;
    logic [ccdpu_pkg::COL_W-1:0]   r_column;
    logic [ccdpu_pkg::ROW_W-1:0]   r_row;
    logic [ccdpu_pkg::PIX_W-1:0]   r_pixel;
    logic                          r_run_last, r_frame_done;

    logic                          emit, last;
    logic [1:0]                    k;
    logic [ccdpu_pkg::PAIR_W-1:0]  pair;

    assign emit = !i_q_empty && (!r_valid || i_pop);

    // cross order within a cell: (0,0) (0,1) (1,1) (1,0)
    always_comb begin
        k    = r_step[1:0];
        pair = i_job.pair;
        last = 1'b0;
        unique case (i_job.kind)
            ccdpu_pkg::KIND_ONE: begin
                k    = i_job.quad;
                last = 1'b1;
            end
            ccdpu_pkg::KIND_CELL: begin
                last = (r_step[1:0] == 2'd3);
            end
            ccdpu_pkg::KIND_CELL2: begin
                if (r_step[2]) begin
                    pair = ccdpu_pkg::PAIR_W'(ccdpu_pkg::HALF_WIDTH - 1);
                end
                last = (r_step == 3'd7);
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    assign o_q_rd = emit && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_step  <= last ? '0 : r_step + 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_column     <= {pair, k[1]};
            r_row        <= {i_job.row_pair, k[1] ^ k[0]};
            r_pixel      <= i_job.pix;
            r_run_last   <= last;
            r_frame_done <= last && i_job.final_word;
        end
    end

    assign o_empty      = !r_valid;
    assign o_column     = r_column;
    assign o_row        = r_row;
    assign o_pixel      = r_pixel;
    assign o_run_last   = r_run_last;
    assign o_frame_done = r_frame_done;

endmodule

// ===== src/ccd_readout_pixel_unpacker_core.sv =====
// Top level of the CCD readout pixel unpacker: register port, front end, job queue, back end.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  input    | push / full        | i_data_byte, i_frame_start
//  result   | empty / pop        | o_column, o_row, o_pixel, o_run_last, o_frame_done
//  config   | psel/penable/pwrite| paddr, pwdata, prdata (pready tied high)
//
// One byte is taken per cycle while full is low. A high byte that lands on a
// data word queues one job; the back end turns a job into 1, 4 or 8 writes at
// one write per cycle while the result is empty or popped, so in binned mode
// the write expander sets the sustained rate.
// Reset is synchronous, active low; it clears positions, registers and queue.
// full rises only when the four-entry job queue is full; a stalled result
// never blocks byte intake until then.
module ccd_readout_pixel_unpacker_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte input
    input  logic                              push,
    output logic                              full,
    input  logic [ccdpu_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                              i_frame_start,
    // pixel writes
    output logic                              empty,
    input  logic                              pop,
    output logic [ccdpu_pkg::COL_W-1:0]       o_column,
    output logic [ccdpu_pkg::ROW_W-1:0]       o_row,
    output logic [ccdpu_pkg::PIX_W-1:0]       o_pixel,
    output logic                              o_run_last,
    output logic                              o_frame_done,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ccdpu_pkg::APB_AW-1:0]      paddr,
    input  logic [ccdpu_pkg::APB_DW-1:0]      pwdata,
    output logic [ccdpu_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    ccdpu_pkg::t_cfg r_cfg;
    ccdpu_pkg::t_job front_job, q_job;
    logic            front_valid, q_full, q_empty, q_rd, reg_wr;

    // Registers sit at word addresses; paddr[1:0] is ignored.
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (reg_wr) begin
            unique case (paddr[3:2])
                ccdpu_pkg::REG_BIN_MODE:       r_cfg.bin_mode       <= pwdata[0];
                ccdpu_pkg::REG_START_ROW_PAIR: r_cfg.start_row_pair <=
                                                   pwdata[ccdpu_pkg::CFG_RP_W-1:0];
                ccdpu_pkg::REG_ROW_PAIRS:      r_cfg.row_pairs      <=
                                                   pwdata[ccdpu_pkg::CFG_RP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            ccdpu_pkg::REG_BIN_MODE:       prdata[0] = r_cfg.bin_mode;
            ccdpu_pkg::REG_START_ROW_PAIR: prdata[ccdpu_pkg::CFG_RP_W-1:0] =
                                               r_cfg.start_row_pair;
            ccdpu_pkg::REG_ROW_PAIRS:      prdata[ccdpu_pkg::CFG_RP_W-1:0] = r_cfg.row_pairs;
            default: ;
        endcase
    end

    assign full = q_full;

    // Front end: pairs bytes, tracks line/frame position, skips headers.
    ccdpu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .i_q_full      (q_full),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_job_valid   (front_valid),
        .o_job         (front_job)
    );

    ccdpu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (front_valid),
        .i_wr_job (front_job),
        .o_full   (q_full),
        .i_rd     (q_rd),
        .o_empty  (q_empty),
        .o_rd_job (q_job)
    );

    // Back end: one pixel write per cycle from the queue head, while the result is empty or popped.
    ccdpu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_job        (q_job),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_column     (o_column),
        .o_row        (o_row),
        .o_pixel      (o_pixel),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

endmodule

// ===== src/ccdpu_checker.sv =====
// Port-level checks for the CCD readout pixel unpacker, bound to the top level.
module ccdpu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic [ccdpu_pkg::COL_W-1:0]   o_column,
    input logic [ccdpu_pkg::ROW_W-1:0]   o_row,
    input logic [ccdpu_pkg::PIX_W-1:0]   o_pixel,
    input logic                          o_run_last,
    input logic                          o_frame_done
);

    // reset leaves no pending write
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // reset leaves the job queue with room
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");

    // frame end only on the closing write of a word
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_done) |-> o_run_last)
        else $error("frame_done without run_last");

    // a waiting write holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_column) && $stable(o_row)
                              && $stable(o_pixel)))
        else $error("pending write changed");

endmodule

bind ccd_readout_pixel_unpacker_core ccdpu_checker u_ccdpu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_column     (o_column),
    .o_row        (o_row),
    .o_pixel      (o_pixel),
    .o_run_last   (o_run_last),
    .o_frame_done (o_frame_done)
);
